>>> sv/tvgp_pkg.sv
// Shared types, constants and the field classifier for the group packer.
// No dependencies; the front, queue, back and top files import this package.
package tvgp_pkg;

   localparam int unsigned GROUP_FIELDS = 4;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_SIGNED   = 2'd0,
      KIND_UNSIGNED = 2'd1,
      KIND_BIASED   = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CODE_COMMON = 2'd0,
      CODE_BYTE   = 2'd1,
      CODE_HALF   = 2'd2,
      CODE_WORD   = 2'd3
   } size_code_type;

   // One classified field as it travels from the front to the back.
   typedef struct packed {
      logic          used;
      size_code_type code;
      logic [31:0]   value;
      logic          last;
   } field_entry_type;

   function automatic size_code_type size_code(input logic [1:0] kind, input logic [31:0] v);
      logic [31:0]   common;
      size_code_type code;
      common = (kind == KIND_BIASED) ? 32'd1 : 32'd0;
      if (v == common) begin
         code = CODE_COMMON;
      end else if (kind == KIND_SIGNED) begin
         if (v[31:7] == {25{v[31]}}) begin
            code = CODE_BYTE;
         end else if (v[31:15] == {17{v[31]}}) begin
            code = CODE_HALF;
         end else begin
            code = CODE_WORD;
         end
      end else begin
         if (v[31:8] == 24'd0) begin
            code = CODE_BYTE;
         end else if (v[31:16] == 16'd0) begin
            code = CODE_HALF;
         end else begin
            code = CODE_WORD;
         end
      end
      return code;
   endfunction

   // Index of the final data byte for a nonzero size code.
   function automatic logic [1:0] last_byte_idx(input size_code_type code);
      logic [1:0] idx;
      unique case (code)
         CODE_BYTE: idx = 2'd0;
         CODE_HALF: idx = 2'd1;
         CODE_WORD: idx = 2'd3;
         default:   idx = 2'd0;
      endcase
      return idx;
   endfunction

endpackage

>>> sv/tvgp_front.sv
// Input side: accepts fields and classifies each into a size code.
// Depends on tvgp_pkg; pushes classified entries into tvgp_queue.
module tvgp_front import tvgp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_kind,
   input  logic [31:0]     req_value,
   input  logic            req_last,
   input  logic            q_full,
   output logic            q_push,
   output field_entry_type q_entry
);

   logic seen_ff, seen_in;

   // Hold off input until the seen register has been set after reset.
   assign seen_in   = 1'b1;
   assign req_stall = q_full | ~seen_ff;
   assign q_push    = req_valid & ~req_stall;

   always_comb begin
      q_entry.used  = (req_kind != KIND_UNUSED);
      q_entry.code  = size_code(req_kind, req_value);
      q_entry.value = req_value;
      q_entry.last  = req_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

>>> sv/tvgp_queue.sv
// Short queue of classified fields between front and back.
// Depends on tvgp_pkg for the entry type and depth.
module tvgp_queue import tvgp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  field_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            nonempty,
   output field_entry_type head
);

   field_entry_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & nonempty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/tvgp_back.sv
// Output side: collects fields into a group, then serializes the
// descriptor and data bytes one per cycle unless rsp is stalled. Depends on tvgp_pkg.
module tvgp_back import tvgp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_nonempty,
   input  field_entry_type q_head,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_record_last
);

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_DESC    = 3'b010,
      ST_DATA    = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [7:0]  desc_ff, desc_in;
   logic        rec_last_ff, rec_last_in;
   logic [31:0] val_ff [GROUP_FIELDS];
   logic [1:0]  cur_slot_ff, cur_slot_in;
   logic [1:0]  cur_byte_ff, cur_byte_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_run_ff, out_run_in;
   logic        out_rec_ff, out_rec_in;

   logic        out_free;
   logic        load;
   logic        take;
   logic        close;
   logic [3:0]  data_mask;
   logic        nxt_found;
   logic [1:0]  nxt_slot;
   logic [2:0]  search_from;
   size_code_type cur_code;

   // Slots that carry data bytes; unfilled slots keep code zero.
   always_comb begin
      for (int s = 0; s < GROUP_FIELDS; s++) begin
         data_mask[s] = (desc_ff[2*s +: 2] != CODE_COMMON);
      end
   end

   assign cur_code    = size_code_type'(desc_ff[{cur_slot_ff, 1'b0} +: 2]);
   assign search_from = (state_ff == ST_DESC) ? 3'd0 : {1'b0, cur_slot_ff} + 3'd1;

   always_comb begin
      nxt_found = 1'b0;
      nxt_slot  = '0;
      for (int s = GROUP_FIELDS - 1; s >= 0; s--) begin
         if (data_mask[s] && (3'(s) >= search_from)) begin
            nxt_found = 1'b1;
            nxt_slot  = 2'(s);
         end
      end
   end

   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign take     = (state_ff == ST_COLLECT) & q_nonempty;
   assign q_pop    = take;
   assign close    = (q_head.used && ({1'b0, cnt_ff} + 3'd1 >= 3'(GROUP_FIELDS)))
                     || q_head.last;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      desc_in     = desc_ff;
      rec_last_in = rec_last_ff;
      cur_slot_in = cur_slot_ff;
      cur_byte_in = cur_byte_ff;
      load        = 1'b0;
      out_byte_in = out_byte_ff;
      out_run_in  = out_run_ff;
      out_rec_in  = out_rec_ff;

      unique case (state_ff)
         ST_COLLECT: begin
            if (take) begin
               if (q_head.used) begin
                  desc_in = desc_ff | (8'(q_head.code) << {cnt_ff, 1'b0});
                  cnt_in  = cnt_ff + 1'b1;
               end
               if (close) begin
                  rec_last_in = q_head.last;
                  state_in    = ST_DESC;
               end
            end
         end
         ST_DESC: begin
            if (out_free) begin
               load        = 1'b1;
               out_byte_in = desc_ff;
               out_run_in  = ~nxt_found;
               out_rec_in  = ~nxt_found & rec_last_ff;
               cur_slot_in = nxt_slot;
               cur_byte_in = '0;
               state_in    = nxt_found ? ST_DATA : ST_COLLECT;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               load        = 1'b1;
               out_byte_in = val_ff[cur_slot_ff][{cur_byte_ff, 3'b000} +: 8];
               if (cur_byte_ff != last_byte_idx(cur_code)) begin
                  cur_byte_in = cur_byte_ff + 1'b1;
                  out_run_in  = 1'b0;
                  out_rec_in  = 1'b0;
               end else begin
                  cur_slot_in = nxt_slot;
                  cur_byte_in = '0;
                  out_run_in  = ~nxt_found;
                  out_rec_in  = ~nxt_found & rec_last_ff;
                  if (!nxt_found) begin
                     state_in = ST_COLLECT;
                  end
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      // Clear the group once its final byte is loaded.
      if (load && out_run_in) begin
         cnt_in  = '0;
         desc_in = '0;
      end
   end

   assign out_valid_in = load ? 1'b1 : (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (take && q_head.used) begin
         val_ff[cnt_ff] <= q_head.value;
      end
      if (load) begin
         out_byte_ff <= out_byte_in;
         out_run_ff  <= out_run_in;
         out_rec_ff  <= out_rec_in;
      end
      cur_slot_ff <= cur_slot_in;
      cur_byte_ff <= cur_byte_in;
      rec_last_ff <= rec_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         cnt_ff       <= '0;
         desc_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         desc_ff      <= desc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_last    = out_run_ff;
   assign rsp_record_last = out_rec_ff;

endmodule

>>> sv/tagged_varint_group_packer.sv
// Channel   Direction  Ports                                   Moves
// req       in         req_valid/req_stall, kind,value,last    one field per transaction
// rsp       out        rsp_valid/rsp_stall, out_byte,run_last,  one packed byte per
//                      record_last                             transaction
//
// A field enters the queue in the cycle it is accepted; the back takes one
// field per cycle while collecting a group and the queue is nonempty. Closing
// a group emits a descriptor byte and 0..16 data bytes, one per cycle unless
// rsp is stalled. Reset is synchronous and active high; input stays stalled
// after it until the front's seen flag is set. A four-entry queue lets the
// front accept fields while the back is stalled. Depends on tvgp_pkg,
// tvgp_front, tvgp_queue and tvgp_back.
module tagged_varint_group_packer import tvgp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_record_last
);

   logic            q_full;
   logic            q_push;
   logic            q_pop;
   logic            q_nonempty;
   field_entry_type q_entry;
   field_entry_type q_head;

   tvgp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_value (req_value),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   tvgp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .nonempty   (q_nonempty),
      .head       (q_head)
   );

   tvgp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_nonempty      (q_nonempty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_record_last (rsp_record_last)
   );

endmodule

>>> sv/tvgp_checker.sv
// Port-level checks for the group packer, bound to the top level.
// Depends only on the top level's ports.
module tvgp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_kind,
   input logic [31:0] req_value,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_run_last,
   input logic        rsp_record_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_record_last))
      else $error("stalled rsp transaction changed");

   a_record_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_last |-> rsp_run_last)
      else $error("record_last without run_last");

   a_reset_rsp_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_reset_req_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("req accepted in the cycle after reset");

endmodule

bind tagged_varint_group_packer tvgp_checker u_tvgp_checker (.*);
